// ----- hw/rtl/rsa_mexp_pkg.sv -----
// Shared types and constants for the RSA modular exponentiation core.
package rsa_mexp_pkg;

   localparam int OPERAND_BITS_DEFAULT = 63;
   localparam int CODE_OFFSET          = 97;
   localparam int CSR_INDEX_BITS       = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/rsa_mexp_mulmod.sv -----
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
module rsa_mexp_mulmod #(
   parameter int OPERAND_BITS = rsa_mexp_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OPERAND_BITS-1:0] a,
   input  logic [OPERAND_BITS-1:0] b,
   input  logic [OPERAND_BITS-1:0] m,
   output logic                    done,
   output logic [OPERAND_BITS-1:0] product
);

   localparam int W  = OPERAND_BITS + 3;
   localparam int CW = $clog2(OPERAND_BITS);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic [OPERAND_BITS-1:0] b_sh_ff, b_sh_in;
   logic [W-1:0]            c_a_ff, c_am_ff, c_a2m_ff, n_m_ff, n_2m_ff;

   logic [W-1:0] a_ext, m_ext, m2_ext, dbl;
   logic [W-1:0] c0, c1, c2, t0, t1, t2, pick;
   logic         bit_cur, last;

   assign a_ext  = {3'b000, a};
   assign m_ext  = {3'b000, m};
   assign m2_ext = {2'b00, m, 1'b0};

   assign bit_cur = b_sh_ff[OPERAND_BITS-1];
   assign dbl     = {2'b00, acc_ff, 1'b0};
   assign c0      = bit_cur ? c_a_ff   : '0;
   assign c1      = bit_cur ? c_am_ff  : n_m_ff;
   assign c2      = bit_cur ? c_a2m_ff : n_2m_ff;
   assign t0      = dbl + c0;
   assign t1      = dbl + c1;
   assign t2      = dbl + c2;
   // 2*acc + a < 3m, so the smallest non-negative candidate is the residue
   assign pick    = !t2[W-1] ? t2 : (!t1[W-1] ? t1 : t0);
   assign last    = (cnt_ff == CW'(OPERAND_BITS - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      b_sh_in = b_sh_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         b_sh_in = b;
      end else if (busy_ff) begin
         acc_in  = pick[OPERAND_BITS-1:0];
         b_sh_in = {b_sh_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff + CW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      b_sh_ff <= b_sh_in;
      if (start) begin
         c_a_ff   <= a_ext;
         c_am_ff  <= a_ext - m_ext;
         c_a2m_ff <= a_ext - m2_ext;
         n_m_ff   <= '0 - m_ext;
         n_2m_ff  <= '0 - m2_ext;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hw/rtl/rsa_mexp_cipher_core.sv -----
// RSA encrypt/decrypt core: square-and-multiply over a bit-serial modular multiplier.
// Every modular multiplication runs in the one shared multiplier; an item needs the base
// reduction plus k further ones (k at most 2*OPERAND_BITS-1). One item at a time, the next
// accepted at the edge the result can leave. Error or degenerate-modulus items go straight
// to the finish state, and an output stall on a pending result holds the item there.
// Synchronous reset: modulus 2, exponents 1.
module rsa_modexp_cipher_core #(
   parameter int OPERAND_BITS = rsa_mexp_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic [OPERAND_BITS-1:0]                 req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [OPERAND_BITS:0]                   rsp_result,
   output logic                                    rsp_error,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rsa_mexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [OPERAND_BITS-1:0]                 csr_wdata
);

   localparam int N = OPERAND_BITS;

   rsa_mexp_pkg::state_type state_ff, state_in;

   logic [N-1:0] mod_ff, pub_ff, priv_ff;
   logic [N-1:0] exp_ff, exp_in;
   logic [N-1:0] acc_ff, acc_in;
   logic [N-1:0] sq_ff, sq_in;
   logic [N-1:0] pow_ff, pow_in;
   logic         kind_ff, kind_in;
   logic         err_ff, err_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [N:0]   rsp_result_ff, rsp_result_in;
   logic         rsp_error_ff;

   logic         mm_start, mm_done;
   logic [N-1:0] mm_a, mm_b, mm_product, exp_shr;
   logic         req_accept, out_free, finish_load;

   rsa_mexp_mulmod #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a       (mm_a),
      .b       (mm_b),
      .m       (mod_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   assign req_stall  = (state_ff != rsa_mexp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == rsa_mexp_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign exp_shr    = {1'b0, exp_ff[N-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff  <= N'(2);
         pub_ff  <= N'(1);
         priv_ff <= N'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rsa_mexp_pkg::CSR_MODULUS:          mod_ff  <= csr_wdata;
            rsa_mexp_pkg::CSR_PUBLIC_EXPONENT:  pub_ff  <= csr_wdata;
            rsa_mexp_pkg::CSR_PRIVATE_EXPONENT: priv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      exp_in      = exp_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      pow_in      = pow_ff;
      kind_in     = kind_ff;
      err_in      = err_ff;
      mm_start    = 1'b0;
      mm_a        = acc_ff;
      mm_b        = sq_ff;
      finish_load = 1'b0;
      case (state_ff)
         rsa_mexp_pkg::ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_kind;
               exp_in  = (req_kind == rsa_mexp_pkg::KIND_DECRYPT) ? priv_ff : pub_ff;
               acc_in  = N'(1);
               err_in  = 1'b0;
               pow_in  = '0;
               if (req_kind == rsa_mexp_pkg::KIND_ENCRYPT &&
                   req_value < N'(rsa_mexp_pkg::CODE_OFFSET)) begin
                  err_in   = 1'b1;
                  state_in = rsa_mexp_pkg::ST_FINISH;
               end else if (mod_ff[N-1:1] == '0) begin
                  state_in = rsa_mexp_pkg::ST_FINISH;
               end else begin
                  // base mod m as 1 * base mod m
                  mm_start = 1'b1;
                  mm_a     = N'(1);
                  mm_b     = (req_kind == rsa_mexp_pkg::KIND_DECRYPT) ? req_value :
                             req_value - N'(rsa_mexp_pkg::CODE_OFFSET);
                  state_in = rsa_mexp_pkg::ST_REDUCE;
               end
            end
         end
         rsa_mexp_pkg::ST_REDUCE: begin
            if (mm_done) begin
               sq_in = mm_product;
               if (exp_ff == '0) begin
                  pow_in   = acc_ff;
                  state_in = rsa_mexp_pkg::ST_FINISH;
               end else if (exp_ff[0]) begin
                  mm_start = 1'b1;
                  mm_a     = acc_ff;
                  mm_b     = mm_product;
                  state_in = rsa_mexp_pkg::ST_MUL_ACC;
               end else begin
                  exp_in   = exp_shr;
                  mm_start = 1'b1;
                  mm_a     = mm_product;
                  mm_b     = mm_product;
                  state_in = rsa_mexp_pkg::ST_MUL_SQ;
               end
            end
         end
         rsa_mexp_pkg::ST_MUL_ACC: begin
            if (mm_done) begin
               acc_in = mm_product;
               exp_in = exp_shr;
               if (exp_shr == '0) begin
                  pow_in   = mm_product;
                  state_in = rsa_mexp_pkg::ST_FINISH;
               end else begin
                  mm_start = 1'b1;
                  mm_a     = sq_ff;
                  mm_b     = sq_ff;
                  state_in = rsa_mexp_pkg::ST_MUL_SQ;
               end
            end
         end
         rsa_mexp_pkg::ST_MUL_SQ: begin
            if (mm_done) begin
               sq_in    = mm_product;
               mm_start = 1'b1;
               if (exp_ff[0]) begin
                  mm_a     = acc_ff;
                  mm_b     = mm_product;
                  state_in = rsa_mexp_pkg::ST_MUL_ACC;
               end else begin
                  exp_in   = exp_shr;
                  mm_a     = mm_product;
                  mm_b     = mm_product;
                  state_in = rsa_mexp_pkg::ST_MUL_SQ;
               end
            end
         end
         rsa_mexp_pkg::ST_FINISH: begin
            if (out_free) begin
               finish_load = 1'b1;
               state_in    = rsa_mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsa_mexp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_result_in = (kind_ff == rsa_mexp_pkg::KIND_DECRYPT) ?
                          {1'b0, pow_ff} + (N + 1)'(rsa_mexp_pkg::CODE_OFFSET) :
                          {1'b0, pow_ff};
   assign rsp_valid_in  = finish_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      pow_ff  <= pow_in;
      kind_ff <= kind_in;
      err_ff  <= err_in;
      if (finish_load) begin
         rsp_result_ff <= rsp_result_in;
         rsp_error_ff  <= err_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_error  = rsp_error_ff;

endmodule

// ----- tb/rsa_modexp_cipher_core_test.sv -----
// Self-checking testbench for the RSA modular exponentiation cipher core.
`timescale 1ns / 1ps

module rsa_modexp_cipher_core_test;

   localparam int OPERAND_BITS  = rsa_mexp_pkg::OPERAND_BITS_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 6_000_000;
   localparam int PHASE_ITEMS   = 20;

   typedef logic [OPERAND_BITS-1:0] operand_type;
   typedef logic [OPERAND_BITS:0]   result_type;

   typedef struct packed {
      result_type result;
      logic       error;
   } cipher_out_type;

   logic                                    clock     = 1'b0;
   logic                                    reset     = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic                                    req_kind  = rsa_mexp_pkg::KIND_ENCRYPT;
   operand_type                             req_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   result_type                              rsp_result;
   logic                                    rsp_error;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [rsa_mexp_pkg::CSR_INDEX_BITS-1:0] csr_index = rsa_mexp_pkg::CSR_MODULUS;
   operand_type                             csr_wdata = '0;

   operand_type    key_modulus  = operand_type'(2);
   operand_type    key_public   = operand_type'(1);
   operand_type    key_private  = operand_type'(1);
   cipher_out_type expected_out[$];
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   int             send_idle_pct  = 0;
   int             stall_pct      = 0;

   rsa_modexp_cipher_core #(
      .OPERAND_BITS(OPERAND_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result),
      .rsp_error  (rsp_error),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic operand_type mod_product(input operand_type a, input operand_type b,
                                               input operand_type m);
      logic [2*OPERAND_BITS-1:0] prod;
      prod = {{OPERAND_BITS{1'b0}}, a} * {{OPERAND_BITS{1'b0}}, b};
      prod = prod % {{OPERAND_BITS{1'b0}}, m};
      return prod[OPERAND_BITS-1:0];
   endfunction

   function automatic operand_type mod_power(input operand_type base,
                                             input operand_type expo,
                                             input operand_type m);
      operand_type acc;
      operand_type sq;
      if (m < operand_type'(2))
         return '0;
      acc = operand_type'(1);
      sq  = base % m;
      for (int i = 0; i < OPERAND_BITS; i++) begin
         if (expo[i])
            acc = mod_product(acc, sq, m);
         sq = mod_product(sq, sq, m);
      end
      return acc;
   endfunction

   function automatic cipher_out_type cipher_outcome(input logic kind,
                                                     input operand_type value);
      cipher_out_type outcome;
      outcome.error = 1'b0;
      if (kind == rsa_mexp_pkg::KIND_ENCRYPT) begin
         if (value < operand_type'(rsa_mexp_pkg::CODE_OFFSET)) begin
            outcome.result = '0;
            outcome.error  = 1'b1;
         end else begin
            outcome.result = {1'b0,
                              mod_power(value - operand_type'(rsa_mexp_pkg::CODE_OFFSET),
                                        key_public, key_modulus)};
         end
      end else begin
         outcome.result = {1'b0, mod_power(value, key_private, key_modulus)}
                          + result_type'(rsa_mexp_pkg::CODE_OFFSET);
      end
      return outcome;
   endfunction

   function automatic operand_type rand_operand();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[OPERAND_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input result_type got,
                                  input result_type want);
      $display("error at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Result channel checker
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_out.size() == 0) begin
            report_mismatch("unexpected transaction, result", rsp_result, '0);
         end else begin
            want = expected_out.pop_front();
            if (rsp_result !== want.result)
               report_mismatch("result", rsp_result, want.result);
            if (rsp_error !== want.error)
               report_mismatch("error flag", result_type'(rsp_error),
                               result_type'(want.error));
         end
      end
   end

   task automatic send_item(input logic kind, input operand_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      expected_out.push_back(cipher_outcome(kind, value));
   endtask

   // Holds the sender off until every outstanding transaction has returned
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_out.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rsa_mexp_pkg::CSR_INDEX_BITS-1:0] index,
                            input operand_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      case (index)
         rsa_mexp_pkg::CSR_MODULUS:          key_modulus = data;
         rsa_mexp_pkg::CSR_PUBLIC_EXPONENT:  key_public  = data;
         rsa_mexp_pkg::CSR_PRIVATE_EXPONENT: key_private = data;
         default: ;
      endcase
   endtask

   task automatic set_key(input operand_type modulus, input operand_type pub,
                          input operand_type priv);
      wait_drain();
      write_reg(rsa_mexp_pkg::CSR_MODULUS, modulus);
      write_reg(rsa_mexp_pkg::CSR_PUBLIC_EXPONENT, pub);
      write_reg(rsa_mexp_pkg::CSR_PRIVATE_EXPONENT, priv);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_key();
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(97));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(98));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(96));
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(5));
   endtask

   task automatic test_textbook_key();
      set_key(operand_type'(3233), operand_type'(17), operand_type'(2753));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(0));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(96));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(97));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(122));
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(0));
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(3232));
   endtask

   task automatic test_exponent_zero();
      set_key(operand_type'(1000003), '0, '0);
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, '1);
      send_item(rsa_mexp_pkg::KIND_DECRYPT, '0);
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(12345));
   endtask

   task automatic test_degenerate_modulus();
      set_key('0, operand_type'(5), operand_type'(5));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(200));
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(7));
      set_key(operand_type'(1), operand_type'(3), operand_type'(3));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, operand_type'(97));
      send_item(rsa_mexp_pkg::KIND_DECRYPT, '1);
   endtask

   task automatic test_operand_extremes();
      set_key('1, '1, '1);
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, '1);
      send_item(rsa_mexp_pkg::KIND_DECRYPT, '1);
      send_item(rsa_mexp_pkg::KIND_DECRYPT, '1 - operand_type'(1));
      set_key('1 - operand_type'(24), operand_type'(1) << (OPERAND_BITS - 1),
              operand_type'(3));
      send_item(rsa_mexp_pkg::KIND_ENCRYPT, '1);
      send_item(rsa_mexp_pkg::KIND_DECRYPT, operand_type'(2));
   endtask

   task automatic set_random_key();
      operand_type modulus;
      operand_type pub;
      operand_type priv;
      if ($urandom_range(3) == 0)
         modulus = operand_type'($urandom_range(2, 65535));
      else
         modulus = rand_operand() >> $urandom_range(0, OPERAND_BITS - 2);
      if (modulus < operand_type'(2))
         modulus = modulus | operand_type'(2);
      pub  = ($urandom_range(7) == 0) ? '0 : operand_type'($urandom_range(1, 65535));
      priv = ($urandom_range(7) == 0) ? '0 : operand_type'($urandom_range(1, 65535));
      set_key(modulus, pub, priv);
   endtask

   task automatic send_random_item();
      logic        kind;
      operand_type value;
      int          pick;
      kind = 1'($urandom_range(1));
      pick = $urandom_range(9);
      if (kind == rsa_mexp_pkg::KIND_ENCRYPT) begin
         if (pick < 5)
            value = operand_type'(rsa_mexp_pkg::CODE_OFFSET + $urandom_range(25));
         else if (pick < 8)
            value = rand_operand();
         else
            value = operand_type'($urandom_range(rsa_mexp_pkg::CODE_OFFSET - 1));
      end else begin
         value = (pick < 6) ? rand_operand() % key_modulus : rand_operand();
      end
      send_item(kind, value);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct_phase);
      set_random_key();
      send_idle_pct = idle_pct;
      stall_pct     = stall_pct_phase;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2)
            set_random_key();
         send_random_item();
      end
      wait_drain();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_textbook_key();
      test_exponent_zero();
      test_degenerate_modulus();
      test_operand_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(55, 0);
      test_random_traffic(0, 55);
      test_random_traffic(25, 25);
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
